### design/png_chunk_stream_checker_core_defines.svh
// Assertion macros shared by the checker RTL.
// No dependencies; include once per asserting module.
`ifndef PNG_CHUNK_STREAM_CHECKER_CORE_DEFINES_SVH
`define PNG_CHUNK_STREAM_CHECKER_CORE_DEFINES_SVH
// Clocked implication check, disabled in reset.
`define PNGCSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked check that also runs during reset.
`define PNGCSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

### design/pngcsc_pkg.sv
// Package for the PNG chunk stream checker: parser state, result record,
// chunk classes, status codes, CRC step and chunk type lookup.
`timescale 1ns / 1ps
package pngcsc_pkg;

  localparam int PALETTE_MAX_DEF = 256;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam int PAL_W = 9;

  typedef enum logic [2:0] {
    PH_SIG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_TYPE = 3'd2,
    PH_DATA = 3'd3,
    PH_CRC  = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    C_IHDR = 4'd0,
    C_PLTE = 4'd1,
    C_TRNS = 4'd2,
    C_IDAT = 4'd3,
    C_IEND = 4'd4,
    C_ANC  = 4'd5,
    C_SKIP = 4'd6,
    C_NONE = 4'd7,
    C_CHRM = 4'd8
  } cls_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_SIG       = 4'd1,
    ST_CRC       = 4'd2,
    ST_IHDR_ORD  = 4'd3,
    ST_IHDR_LEN  = 4'd4,
    ST_DEPTH     = 4'd5,
    ST_DEPTH_CT  = 4'd6,
    ST_COMPRESS  = 4'd7,
    ST_FILTER    = 4'd8,
    ST_INTERLACE = 4'd9,
    ST_MISPLACED = 4'd10,
    ST_PLTE_LEN  = 4'd11,
    ST_TRNS_LEN  = 4'd12,
    ST_UNKNOWN   = 4'd13,
    ST_TRNS_CT   = 4'd14
  } status_t;

  // Seen-flag bit positions.
  localparam int F_IHDR = 0;
  localparam int F_PLTE = 1;
  localparam int F_IDAT = 2;
  localparam int F_TRNS = 3;
  localparam int F_CHRM = 4;

  typedef struct packed {
    phase_t             phase;
    logic [31:0]        idx;
    logic [31:0]        len;
    logic [31:0]        typ;
    logic [31:0]        crc;
    logic [31:0]        scrc;
    logic [4:0]         seen;
    logic [39:0]        hdr;
    logic [31:0]        width;
    logic [31:0]        height;
    logic [4:0]         depth;
    logic [2:0]         chans;
    logic [PAL_W-1:0]   pal;
    logic               halted;
    logic               sig_bad;
    logic               inter;
    cls_t               cls;
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  code;
    logic [30:0] len;
    logic [3:0]  status;
    logic [31:0] width;
    logic [31:0] height;
    logic [4:0]  depth;
    logic [2:0]  chans;
    logic        inter;
    logic        last;
  } result_t;

  function automatic state_t reset_state();
    state_t s;
    s         = '0;
    s.phase   = PH_SIG;
    s.crc     = '1;
    s.cls     = C_NONE;
    return s;
  endfunction

  function automatic logic [31:0] crc_byte(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

  function automatic logic [7:0] sig_byte(logic [2:0] i);
    logic [7:0] v;
    unique case (i)
      3'd0:    v = 8'h89;
      3'd1:    v = 8'h50;
      3'd2:    v = 8'h4E;
      3'd3:    v = 8'h47;
      3'd4:    v = 8'h0D;
      3'd5:    v = 8'h0A;
      3'd6:    v = 8'h1A;
      default: v = 8'h0A;
    endcase
    return v;
  endfunction

  function automatic cls_t classify(logic [31:0] t);
    cls_t c;
    unique case (t)
      32'h49484452: c = C_IHDR;
      32'h504C5445: c = C_PLTE;
      32'h74524E53: c = C_TRNS;
      32'h49444154: c = C_IDAT;
      32'h49454E44: c = C_IEND;
      32'h6348524D: c = C_CHRM;
      32'h63494350, 32'h67414D41, 32'h69434350, 32'h6D444356,
      32'h634C4C49, 32'h73424954, 32'h73524742, 32'h624B4744,
      32'h68495354, 32'h65584966, 32'h6663544C, 32'h6163544C,
      32'h70485973, 32'h73504C54, 32'h66644154: c = C_ANC;
      32'h43674249, 32'h74494D45, 32'h69545874,
      32'h74455874, 32'h7A545874: c = C_SKIP;
      default: c = C_NONE;
    endcase
    return c;
  endfunction

endpackage

### design/pngcsc_step.sv
// Next-state and result logic for one stream byte of the PNG checker.
// Depends on pngcsc_pkg.
`timescale 1ns / 1ps
module pngcsc_step #(
  parameter int PALETTE_MAX = pngcsc_pkg::PALETTE_MAX_DEF
) (
  input  pngcsc_pkg::state_t  cur,
  input  logic [7:0]          in_byte,
  input  logic                start,
  output pngcsc_pkg::state_t  nxt,
  output logic                res_valid,
  output pngcsc_pkg::result_t res
);

  localparam logic [31:0] PLTE_MAX_LEN = 32'(PALETTE_MAX * 3);

  pngcsc_pkg::state_t  s;
  pngcsc_pkg::cls_t    ecls;
  logic                emit;
  logic                ekind;
  logic [7:0]          epay;
  logic [3:0]          est;
  logic                eend;
  logic                clr_len;
  logic [31:0]         idx_inc;
  logic [31:0]         typ_new;
  logic [9:0]          len10;
  logic [20:0]         q_prod;
  logic [9:0]          q3;
  logic [9:0]          rem3;
  logic [7:0]          d;
  logic [7:0]          ct;
  logic [3:0]          st;

  always_comb begin
    s        = start ? pngcsc_pkg::reset_state() : cur;
    emit     = 1'b0;
    ekind    = 1'b1;
    epay     = '0;
    ecls     = s.cls;
    est      = pngcsc_pkg::ST_OK;
    eend     = 1'b0;
    clr_len  = 1'b0;
    idx_inc  = s.idx + 32'd1;
    typ_new  = {s.typ[23:0], in_byte};
    len10    = s.len[9:0];
    q_prod   = 21'(len10) * 21'd683;   // divide by 3 for values below 2048
    q3       = q_prod[20:11];
    rem3     = len10 - 10'(q3 * 10'd3);
    d        = s.hdr[39:32];
    ct       = s.hdr[31:24];
    st       = pngcsc_pkg::ST_OK;

    if (!s.halted) begin
      unique case (s.phase)
        pngcsc_pkg::PH_SIG: begin
          if (in_byte != pngcsc_pkg::sig_byte(s.idx[2:0])) s.sig_bad = 1'b1;
          if (s.idx[2:0] == 3'd7) begin
            s.idx   = '0;
            s.phase = pngcsc_pkg::PH_LEN;
            emit    = 1'b1;
            ecls    = pngcsc_pkg::C_NONE;
            if (s.sig_bad) begin
              s.halted = 1'b1;
              est      = pngcsc_pkg::ST_SIG;
              eend     = 1'b1;
            end
          end else begin
            s.idx = idx_inc;
          end
        end

        pngcsc_pkg::PH_LEN: begin
          s.len = {s.len[23:0], in_byte};
          if (s.idx[1:0] == 2'd3) begin
            s.idx   = '0;
            s.phase = pngcsc_pkg::PH_TYPE;
            s.crc   = '1;
            s.typ   = '0;
          end else begin
            s.idx = idx_inc;
          end
        end

        pngcsc_pkg::PH_TYPE: begin
          s.typ = typ_new;
          s.crc = pngcsc_pkg::crc_byte(s.crc, in_byte);
          if (s.idx[1:0] == 2'd3) begin
            s.idx = '0;
            s.cls = pngcsc_pkg::classify(typ_new);
            priority if (s.cls == pngcsc_pkg::C_NONE) begin
              st = pngcsc_pkg::ST_UNKNOWN;
            end else if (!s.seen[pngcsc_pkg::F_IHDR] && s.cls != pngcsc_pkg::C_IHDR) begin
              st = pngcsc_pkg::ST_IHDR_ORD;
            end else if (s.cls == pngcsc_pkg::C_IHDR) begin
              if (s.seen[pngcsc_pkg::F_IHDR]) st = pngcsc_pkg::ST_IHDR_ORD;
              else if (s.len != 32'd13) st = pngcsc_pkg::ST_IHDR_LEN;
              else s.seen[pngcsc_pkg::F_IHDR] = 1'b1;
            end else if (s.cls == pngcsc_pkg::C_PLTE) begin
              if (s.seen[pngcsc_pkg::F_PLTE] || s.seen[pngcsc_pkg::F_IDAT])
                st = pngcsc_pkg::ST_MISPLACED;
              else if (s.len > PLTE_MAX_LEN || rem3 != 10'd0)
                st = pngcsc_pkg::ST_PLTE_LEN;
              else begin
                s.pal = q3[pngcsc_pkg::PAL_W-1:0];
                s.seen[pngcsc_pkg::F_PLTE] = 1'b1;
              end
            end else if (s.cls == pngcsc_pkg::C_TRNS) begin
              if (s.seen[pngcsc_pkg::F_TRNS] || s.seen[pngcsc_pkg::F_IDAT])
                st = pngcsc_pkg::ST_MISPLACED;
              else if (s.seen[pngcsc_pkg::F_PLTE]) begin
                if (s.len > 32'(s.pal)) st = pngcsc_pkg::ST_TRNS_LEN;
              end else if (!s.chans[0]) begin
                st = pngcsc_pkg::ST_TRNS_CT;
              end else if (s.len != {28'd0, s.chans, 1'b0}) begin
                st = pngcsc_pkg::ST_TRNS_LEN;
              end
              if (st == pngcsc_pkg::ST_OK) s.seen[pngcsc_pkg::F_TRNS] = 1'b1;
            end else if (s.cls == pngcsc_pkg::C_CHRM) begin
              if (s.seen[pngcsc_pkg::F_PLTE] || s.seen[pngcsc_pkg::F_IDAT] ||
                  s.seen[pngcsc_pkg::F_CHRM])
                st = pngcsc_pkg::ST_MISPLACED;
              else s.seen[pngcsc_pkg::F_CHRM] = 1'b1;
            end else begin
              if (s.cls == pngcsc_pkg::C_IDAT) s.seen[pngcsc_pkg::F_IDAT] = 1'b1;
            end
            if (st != pngcsc_pkg::ST_OK) begin
              s.halted = 1'b1;
              emit     = 1'b1;
              ecls     = s.cls;
              est      = st;
              eend     = 1'b1;
            end else begin
              s.hdr   = '0;
              s.phase = (s.len != 32'd0) ? pngcsc_pkg::PH_DATA : pngcsc_pkg::PH_CRC;
            end
          end else begin
            s.idx = idx_inc;
          end
        end

        pngcsc_pkg::PH_DATA: begin
          s.crc = pngcsc_pkg::crc_byte(s.crc, in_byte);
          if (idx_inc >= s.len) begin
            s.idx   = '0;
            s.phase = pngcsc_pkg::PH_CRC;
          end else begin
            s.idx = idx_inc;
          end
          if (s.cls == pngcsc_pkg::C_IHDR) begin
            if (cur.idx < 32'd4 || start) s.width = {s.width[23:0], in_byte};
            else if (cur.idx < 32'd8) s.height = {s.height[23:0], in_byte};
            else s.hdr = {s.hdr[31:0], in_byte};
            if (cur.idx == 32'd12 && !start) begin
              d  = s.hdr[39:32];
              ct = s.hdr[31:24];
              priority if (d != 8'd8 && d != 8'd16) st = pngcsc_pkg::ST_DEPTH;
              else if ((ct != 8'd0 && ct != 8'd2 && ct != 8'd3 && ct != 8'd4 &&
                        ct != 8'd6) || (ct == 8'd3 && d == 8'd16))
                st = pngcsc_pkg::ST_DEPTH_CT;
              else if (s.hdr[23:16] != 8'd0) st = pngcsc_pkg::ST_COMPRESS;
              else if (s.hdr[15:8] != 8'd0) st = pngcsc_pkg::ST_FILTER;
              else if (s.hdr[7:0] > 8'd1) st = pngcsc_pkg::ST_INTERLACE;
              else st = pngcsc_pkg::ST_OK;
              if (st != pngcsc_pkg::ST_OK) begin
                s.halted = 1'b1;
                emit     = 1'b1;
                est      = st;
                eend     = 1'b1;
              end else begin
                s.depth = d[4:0];
                s.chans = 3'd1 + {1'b0, ct[1], 1'b0} + {2'd0, ct[2]};
                s.inter = s.hdr[0];
              end
            end
          end else if (s.cls == pngcsc_pkg::C_IDAT) begin
            emit  = 1'b1;
            ekind = 1'b0;
            epay  = in_byte;
            ecls  = pngcsc_pkg::C_IDAT;
          end
        end

        pngcsc_pkg::PH_CRC: begin
          s.scrc = {s.scrc[23:0], in_byte};
          if (s.idx[1:0] == 2'd3) begin
            s.idx   = '0;
            s.phase = pngcsc_pkg::PH_LEN;
            emit    = 1'b1;
            if (s.cls != pngcsc_pkg::C_SKIP && s.scrc != ~s.crc) begin
              s.halted = 1'b1;
              est      = pngcsc_pkg::ST_CRC;
              eend     = 1'b1;
            end else begin
              if (s.cls == pngcsc_pkg::C_TRNS && s.seen[pngcsc_pkg::F_PLTE] &&
                  s.chans != 3'd7)
                s.chans = s.chans + 3'd1;
              if (s.cls == pngcsc_pkg::C_IEND) begin
                s.halted = 1'b1;
                eend     = 1'b1;
              end else begin
                clr_len = 1'b1;
              end
            end
          end else begin
            s.idx = idx_inc;
          end
        end

        default: s.halted = 1'b1;
      endcase
    end

    res_valid   = emit;
    res.kind    = ekind;
    res.payload = epay;
    res.code    = (ecls == pngcsc_pkg::C_CHRM) ? 3'(pngcsc_pkg::C_ANC) : ecls[2:0];
    res.len     = s.len[30:0];
    res.status  = est;
    res.width   = s.width;
    res.height  = s.height;
    res.depth   = s.depth;
    res.chans   = s.chans;
    res.inter   = s.inter;
    res.last    = eend;
    if (clr_len) s.len = '0;
    nxt = s;
  end

endmodule

### design/png_chunk_stream_checker_core.sv
// PNG chunk stream checker, top level: one byte per transfer in, one result
// register out. A result is registered and appears in the cycle after its byte
// transfer. Throughput: one byte per cycle; the output register holds under stall
// and the input side accepts whenever that register is empty or being drained.
// Reset (rst, synchronous, active high) returns the parser to the signature
// phase and empties the result register; frame_start resets just the parser.
`timescale 1ns / 1ps
`include "png_chunk_stream_checker_core_defines.svh"
module png_chunk_stream_checker_core #(
  parameter int PALETTE_MAX = pngcsc_pkg::PALETTE_MAX_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] stream_byte
  input  logic         s_tuser,   // [0] frame_start
  output logic         m_tvalid,
  input  logic         m_tready,
  // [7:0] payload_byte, [10:8] chunk_code, [41:11] chunk_length,
  // [45:42] status, [77:46] image_width, [109:78] image_height,
  // [114:110] bit_depth, [117:115] channel_count, [118] interlaced, [119] 0
  output logic [119:0] m_tdata,
  output logic         m_tuser,   // [0] report_kind
  output logic         m_tlast    // stream_end
);

  pngcsc_pkg::state_t  state;
  pngcsc_pkg::state_t  state_next;
  pngcsc_pkg::result_t res_next;
  pngcsc_pkg::result_t res;
  logic                res_valid_next;
  logic                in_fire;
  logic                halt_hold;
  logic                payload_out;
  logic                payload_clean;

  // Take a byte whenever the result register is free or drains this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  pngcsc_step #(
    .PALETTE_MAX(PALETTE_MAX)
  ) u_step (
    .cur       (state),
    .in_byte   (s_tdata),
    .start     (s_tuser),
    .nxt       (state_next),
    .res_valid (res_valid_next),
    .res       (res_next)
  );

  // Advance parser state only on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pngcsc_pkg::reset_state();
    end else if (in_fire) begin
      state <= state_next;
    end
  end

  // Result register: load on a transfer that yields a result, drop on drain.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire) begin
      m_tvalid <= res_valid_next;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid_next) begin
      res <= res_next;
    end
  end

  assign m_tdata = {1'b0, res.inter, res.chans, res.depth, res.height, res.width,
                    res.status, res.len, res.code, res.payload};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  // Check terms: a byte reaching a halted parser without a frame restart,
  // and a payload transfer with its report fields.
  assign halt_hold     = in_fire && state.halted && !s_tuser;
  assign payload_out   = m_tvalid && !m_tuser;
  assign payload_clean = (res.status == pngcsc_pkg::ST_OK) && !m_tlast;

  // A halted parser leaves its state halted unless a frame restarts it.
  `PNGCSC_ASSERT(a_halt_holds, halt_hold |=> state.halted, "halted parser resumed")
  // Payload results carry status OK and never end the stream.
  `PNGCSC_ASSERT(a_payload_clean, payload_out |-> payload_clean, "payload with report fields")
  // Every stream-ending result leaves the parser halted.
  `PNGCSC_ASSERT(a_end_halts, (m_tvalid && m_tlast) |-> state.halted, "stream end without halt")

endmodule

### tb/sv/png_chunk_stream_checker_core_tb.sv
// Self-checking bench for png_chunk_stream_checker_core: builds PNG-like byte
// streams, predicts the report and payload transfers, checks them in order.
// Depends on pngcsc_pkg and the core RTL.
`timescale 1ns / 1ps
module png_chunk_stream_checker_core_tb;

  typedef struct packed {
    logic       first;
    logic [7:0] data;
  } byte_item_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [119:0] m_tdata;
  logic         m_tuser;
  logic         m_tlast;

  png_chunk_stream_checker_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  // ---------------- parser model ----------------
  pngcsc_pkg::phase_t p_phase;
  logic [31:0]        p_idx, p_len, p_typ, p_crc, p_scrc, p_w, p_h;
  logic [4:0]         p_seen, p_depth;
  logic [39:0]        p_hdr;
  logic [2:0]         p_chans;
  logic [8:0]         p_pal;
  logic               p_halted, p_sigbad, p_inter;
  pngcsc_pkg::cls_t   p_cls;

  function automatic logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) r = (r >> 1) ^ (pngcsc_pkg::CRC_POLY & {32{r[0]}});
    return r;
  endfunction

  function automatic pngcsc_pkg::cls_t chunk_class(logic [31:0] t);
    case (t)
      32'h49484452: return pngcsc_pkg::C_IHDR;
      32'h504C5445: return pngcsc_pkg::C_PLTE;
      32'h74524E53: return pngcsc_pkg::C_TRNS;
      32'h49444154: return pngcsc_pkg::C_IDAT;
      32'h49454E44: return pngcsc_pkg::C_IEND;
      32'h6348524D: return pngcsc_pkg::C_CHRM;
      32'h63494350, 32'h67414D41, 32'h69434350, 32'h6D444356, 32'h634C4C49,
      32'h73424954, 32'h73524742, 32'h624B4744, 32'h68495354, 32'h65584966,
      32'h6663544C, 32'h6163544C, 32'h70485973, 32'h73504C54, 32'h66644154:
        return pngcsc_pkg::C_ANC;
      32'h43674249, 32'h74494D45, 32'h69545874, 32'h74455874, 32'h7A545874:
        return pngcsc_pkg::C_SKIP;
      default: return pngcsc_pkg::C_NONE;
    endcase
  endfunction

  task automatic parser_clear();
    p_phase = pngcsc_pkg::PH_SIG; p_idx = 0; p_len = 0; p_typ = 0; p_crc = '1;
    p_scrc = 0; p_seen = 0; p_hdr = 0; p_w = 0; p_h = 0; p_depth = 0; p_chans = 0;
    p_pal = 0; p_halted = 0; p_sigbad = 0; p_inter = 0; p_cls = pngcsc_pkg::C_NONE;
  endtask

  function automatic pngcsc_pkg::result_t make_result(logic kind, logic [7:0] pay,
                                                      pngcsc_pkg::cls_t c,
                                                      pngcsc_pkg::status_t st,
                                                      logic last);
    pngcsc_pkg::result_t r;
    r.kind = kind; r.payload = pay;
    r.code = (c == pngcsc_pkg::C_CHRM) ? 3'(pngcsc_pkg::C_ANC) : c[2:0];
    r.len = p_len[30:0]; r.status = st; r.width = p_w; r.height = p_h;
    r.depth = p_depth; r.chans = p_chans; r.inter = p_inter; r.last = last;
    return r;
  endfunction

  function automatic pngcsc_pkg::status_t chunk_order_check();
    if (p_cls == pngcsc_pkg::C_NONE) return pngcsc_pkg::ST_UNKNOWN;
    if (!p_seen[pngcsc_pkg::F_IHDR] && p_cls != pngcsc_pkg::C_IHDR)
      return pngcsc_pkg::ST_IHDR_ORD;
    case (p_cls)
      pngcsc_pkg::C_IHDR: begin
        if (p_seen[pngcsc_pkg::F_IHDR]) return pngcsc_pkg::ST_IHDR_ORD;
        if (p_len != 13) return pngcsc_pkg::ST_IHDR_LEN;
        p_seen[pngcsc_pkg::F_IHDR] = 1;
      end
      pngcsc_pkg::C_PLTE: begin
        if (p_seen[pngcsc_pkg::F_PLTE] || p_seen[pngcsc_pkg::F_IDAT])
          return pngcsc_pkg::ST_MISPLACED;
        if (p_len > pngcsc_pkg::PALETTE_MAX_DEF * 3 || p_len % 3 != 0)
          return pngcsc_pkg::ST_PLTE_LEN;
        p_pal = 9'(p_len / 3);
        p_seen[pngcsc_pkg::F_PLTE] = 1;
      end
      pngcsc_pkg::C_TRNS: begin
        if (p_seen[pngcsc_pkg::F_TRNS] || p_seen[pngcsc_pkg::F_IDAT])
          return pngcsc_pkg::ST_MISPLACED;
        if (p_seen[pngcsc_pkg::F_PLTE]) begin
          if (p_len > p_pal) return pngcsc_pkg::ST_TRNS_LEN;
        end else begin
          if (!p_chans[0]) return pngcsc_pkg::ST_TRNS_CT;
          if (p_len != 2 * p_chans) return pngcsc_pkg::ST_TRNS_LEN;
        end
        p_seen[pngcsc_pkg::F_TRNS] = 1;
      end
      pngcsc_pkg::C_CHRM: begin
        if (p_seen[pngcsc_pkg::F_PLTE] || p_seen[pngcsc_pkg::F_IDAT] ||
            p_seen[pngcsc_pkg::F_CHRM])
          return pngcsc_pkg::ST_MISPLACED;
        p_seen[pngcsc_pkg::F_CHRM] = 1;
      end
      pngcsc_pkg::C_IDAT: p_seen[pngcsc_pkg::F_IDAT] = 1;
      default: ;
    endcase
    return pngcsc_pkg::ST_OK;
  endfunction

  function automatic pngcsc_pkg::status_t header_field_check();
    logic [7:0] d, ct;
    d = p_hdr[39:32]; ct = p_hdr[31:24];
    if (d != 8 && d != 16) return pngcsc_pkg::ST_DEPTH;
    if (!(ct inside {0, 2, 3, 4, 6}) || (ct == 3 && d == 16))
      return pngcsc_pkg::ST_DEPTH_CT;
    if (p_hdr[23:16] != 0) return pngcsc_pkg::ST_COMPRESS;
    if (p_hdr[15:8] != 0) return pngcsc_pkg::ST_FILTER;
    if (p_hdr[7:0] > 1) return pngcsc_pkg::ST_INTERLACE;
    p_depth = d[4:0];
    p_chans = 3'(1 + (ct & 2) + ((ct >> 2) & 1));
    p_inter = (p_hdr[7:0] != 8'd0);
    return pngcsc_pkg::ST_OK;
  endfunction

  pngcsc_pkg::result_t expected_results[$];

  task automatic fail_report(pngcsc_pkg::status_t st);
    p_halted = 1;
    expected_results.push_back(make_result(1'b1, 8'd0, p_cls, st, 1'b1));
  endtask

  task automatic parse_byte(byte_item_t it);
    logic [7:0]          b;
    logic [31:0]         pos;
    pngcsc_pkg::status_t st;
    b = it.data;
    if (it.first) parser_clear();
    if (p_halted) return;
    case (p_phase)
      pngcsc_pkg::PH_SIG: begin
        if (b != pngcsc_pkg::sig_byte(p_idx[2:0])) p_sigbad = 1;
        p_idx++;
        if (p_idx == 8) begin
          p_idx = 0; p_phase = pngcsc_pkg::PH_LEN;
          if (p_sigbad) fail_report(pngcsc_pkg::ST_SIG);
          else expected_results.push_back(make_result(1'b1, 8'd0, pngcsc_pkg::C_NONE,
                                                       pngcsc_pkg::ST_OK, 1'b0));
        end
      end
      pngcsc_pkg::PH_LEN: begin
        p_len = {p_len[23:0], b};
        if (++p_idx == 4) begin
          p_idx = 0; p_phase = pngcsc_pkg::PH_TYPE; p_crc = '1; p_typ = 0;
        end
      end
      pngcsc_pkg::PH_TYPE: begin
        p_typ = {p_typ[23:0], b};
        p_crc = crc_step(p_crc, b);
        if (++p_idx == 4) begin
          p_idx = 0;
          p_cls = chunk_class(p_typ);
          st = chunk_order_check();
          if (st != pngcsc_pkg::ST_OK) fail_report(st);
          else begin
            p_hdr = 0;
            p_phase = (p_len != 0) ? pngcsc_pkg::PH_DATA : pngcsc_pkg::PH_CRC;
          end
        end
      end
      pngcsc_pkg::PH_DATA: begin
        pos = p_idx;
        p_crc = crc_step(p_crc, b);
        p_idx++;
        if (p_idx >= p_len) begin
          p_idx = 0; p_phase = pngcsc_pkg::PH_CRC;
        end
        if (p_cls == pngcsc_pkg::C_IHDR) begin
          if (pos < 4) p_w = {p_w[23:0], b};
          else if (pos < 8) p_h = {p_h[23:0], b};
          else p_hdr = {p_hdr[31:0], b};
          if (pos == 12) begin
            st = header_field_check();
            if (st != pngcsc_pkg::ST_OK) fail_report(st);
          end
        end else if (p_cls == pngcsc_pkg::C_IDAT) begin
          expected_results.push_back(make_result(1'b0, b, pngcsc_pkg::C_IDAT,
                                                 pngcsc_pkg::ST_OK, 1'b0));
        end
      end
      pngcsc_pkg::PH_CRC: begin
        p_scrc = {p_scrc[23:0], b};
        if (++p_idx == 4) begin
          p_idx = 0; p_phase = pngcsc_pkg::PH_LEN;
          if (p_cls != pngcsc_pkg::C_SKIP && p_scrc != ~p_crc)
            fail_report(pngcsc_pkg::ST_CRC);
          else begin
            if (p_cls == pngcsc_pkg::C_TRNS && p_seen[pngcsc_pkg::F_PLTE] && p_chans < 7)
              p_chans++;
            if (p_cls == pngcsc_pkg::C_IEND) begin
              p_halted = 1;
              expected_results.push_back(make_result(1'b1, 8'd0, pngcsc_pkg::C_IEND,
                                                     pngcsc_pkg::ST_OK, 1'b1));
            end else begin
              expected_results.push_back(make_result(1'b1, 8'd0, p_cls,
                                                     pngcsc_pkg::ST_OK, 1'b0));
              p_len = 0;
            end
          end
        end
      end
      default: p_halted = 1;
    endcase
  endtask

  // ---------------- stream builder ----------------
  byte_item_t pending_bytes[$];
  int         bytes_built = 0;
  int         idle_bias = 20;   // percent chance of starting an idle burst
  bit         hold_sink = 1'b0;

  task automatic put_byte(logic [7:0] b, logic first = 1'b0);
    byte_item_t it;
    it.first = first; it.data = b;
    pending_bytes.push_back(it);
    bytes_built++;
  endtask

  task automatic put_signature(bit corrupt);
    for (int i = 0; i < 8; i++) begin
      logic [7:0] b;
      b = pngcsc_pkg::sig_byte(3'(i));
      if (corrupt && i == 3) b = b ^ 8'(1 << $urandom_range(7));
      put_byte(b, i == 0);
    end
  endtask

  // Length and type only; the parser stops or restarts before any data.
  task automatic put_header_only(logic [31:0] tag, logic [31:0] n);
    for (int i = 3; i >= 0; i--) put_byte(n[8*i +: 8]);
    for (int i = 3; i >= 0; i--) put_byte(tag[8*i +: 8]);
  endtask

  // One chunk: length, type, data and CRC; bad_crc flips a CRC bit.
  task automatic put_chunk(logic [31:0] tag, logic [7:0] body[$], bit bad_crc = 1'b0);
    logic [31:0] c, n;
    c = '1;
    n = body.size();
    for (int i = 3; i >= 0; i--) put_byte(n[8*i +: 8]);
    for (int i = 3; i >= 0; i--) begin
      put_byte(tag[8*i +: 8]); c = crc_step(c, tag[8*i +: 8]);
    end
    foreach (body[i]) begin
      put_byte(body[i]); c = crc_step(c, body[i]);
    end
    c = ~c;
    if (bad_crc) c[$urandom_range(31)] ^= 1'b1;
    for (int i = 3; i >= 0; i--) put_byte(c[8*i +: 8]);
  endtask

  function automatic void rand_body(ref logic [7:0] q[$], input int n);
    q = {};
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
  endfunction

  task automatic put_ihdr(logic [31:0] w, logic [31:0] h, logic [7:0] d,
                          logic [7:0] ct, logic [7:0] cm, logic [7:0] fm,
                          logic [7:0] im);
    logic [7:0] q[$];
    q = {w[31:24], w[23:16], w[15:8], w[7:0], h[31:24], h[23:16], h[15:8], h[7:0],
         d, ct, cm, fm, im};
    put_chunk(32'h49484452, q);
  endtask

  // Mostly well formed image, with an occasional defect.
  task automatic put_image();
    logic [7:0] q[$];
    logic [7:0] ct, d;
    int         chans, defect, npal;
    logic [31:0] anc[5];
    anc = '{32'h67414D41, 32'h70485973, 32'h73524742, 32'h624B4744, 32'h66644154};
    defect = ($urandom_range(3) == 0) ? $urandom_range(1, 9) : 0;
    ct = 8'($urandom_range(4)); ct = (ct == 1) ? 8'd3 : (ct == 4 ? 8'd6 : ct);
    if ($urandom_range(1)) ct = 8'd4;
    d = (ct == 3 || $urandom_range(1)) ? 8'd8 : 8'd16;
    chans = 1 + (ct & 2) + ((ct >> 2) & 1);
    put_signature(defect == 1);
    case (defect)
      2: put_ihdr($urandom, $urandom, 8'($urandom_range(20)), ct, 8'd0, 8'd0, 8'd0);
      3: put_ihdr($urandom, $urandom, d, 8'($urandom), 8'd0, 8'd0, 8'd0);
      4: put_ihdr($urandom, $urandom, d, ct, 8'($urandom_range(1, 255)),
                  8'($urandom_range(1)), 8'($urandom_range(3)));
      default: put_ihdr($urandom, $urandom, d, ct, 8'd0, 8'd0, 8'($urandom_range(1)));
    endcase
    if ($urandom_range(2) == 0) begin
      rand_body(q, 32); put_chunk(32'h6348524D, q);
    end
    if (ct == 3 || $urandom_range(3) == 0) begin
      npal = $urandom_range(1, 8);
      rand_body(q, defect == 5 ? npal * 3 + 1 : npal * 3);
      put_chunk(32'h504C5445, q);
      if ($urandom_range(1)) begin
        rand_body(q, $urandom_range(0, defect == 6 ? npal + 2 : npal));
        put_chunk(32'h74524E53, q);
      end
    end else if ($urandom_range(2) == 0) begin
      rand_body(q, defect == 6 ? $urandom_range(7) : 2 * chans);
      put_chunk(32'h74524E53, q);
    end
    for (int k = $urandom_range(1, 3); k > 0; k--) begin
      if ($urandom_range(2) == 0) begin
        rand_body(q, $urandom_range(6)); put_chunk(anc[$urandom_range(4)], q);
      end
      if ($urandom_range(3) == 0) begin
        rand_body(q, $urandom_range(6));
        put_chunk(32'h74455874, q, 1'($urandom_range(1)));   // skipped, CRC ignored
      end
      rand_body(q, $urandom_range(0, 40));
      put_chunk(32'h49444154, q, defect == 7 && k == 1);
    end
    if (defect == 8) begin
      rand_body(q, 3); put_chunk(32'h504C5445, q);   // palette after data
    end
    if (defect == 9) begin
      rand_body(q, 2); put_chunk($urandom, q);
    end
    q = {};
    put_chunk(32'h49454E44, q);
    for (int k = $urandom_range(2); k > 0; k--) put_byte(8'($urandom));  // ignored
  endtask

  // ---------------- driver ----------------
  int gap_left;
  int items_sent = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0; s_tdata <= '0; s_tuser <= 1'b0; gap_left <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) items_sent <= items_sent + 1;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() > 0 && $urandom_range(99) >= idle_bias) begin
        byte_item_t it;
        it = pending_bytes.pop_front();
        parse_byte(it);
        s_tvalid <= 1'b1; s_tdata <= it.data; s_tuser <= it.first;
      end else begin
        s_tvalid <= 1'b0;
        if (pending_bytes.size() > 0) gap_left <= $urandom_range(0, 2);
      end
    end
  end

  // ---------------- monitor and receiver ----------------
  int mismatches = 0;
  int reports_seen = 0;
  int payloads_seen = 0;
  int idle_cycles = 0;
  int stall_left;
  bit timed_out = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0; stall_left <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        pngcsc_pkg::result_t got, want;
        got.kind = m_tuser; got.payload = m_tdata[7:0]; got.code = m_tdata[10:8];
        got.len = m_tdata[41:11]; got.status = m_tdata[45:42];
        got.width = m_tdata[77:46]; got.height = m_tdata[109:78];
        got.depth = m_tdata[114:110]; got.chans = m_tdata[117:115];
        got.inter = m_tdata[118]; got.last = m_tlast;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || m_tdata[119] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %h actual %h", want, got);
          end
          if (got.kind) reports_seen++; else payloads_seen++;
        end
      end
      // Receiver: long hold-off on request, else random stalls.
      if (hold_sink) m_tready <= 1'b0;
      else if (stall_left > 0) begin
        stall_left <= stall_left - 1; m_tready <= 1'b0;
      end else if ($urandom_range(99) < idle_bias) begin
        stall_left <= $urandom_range(0, 2); m_tready <= 1'b0;
      end else m_tready <= 1'b1;
      // Watchdog on cycles with no transfer at all.
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || hold_sink) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("png_chunk_stream_checker_core test failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] q[$];
    rst = 1'b1;
    parser_clear();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: minimal valid file with extreme header fields.
    put_signature(0);
    put_ihdr('1, 32'h0, 8'd16, 8'd6, 8'd0, 8'd0, 8'd1);
    rand_body(q, 4); put_chunk(32'h49444154, q);
    q = {}; put_chunk(32'h49454E44, q);
    // Corrupt signature, then further error classes, one per frame.
    put_signature(1);
    put_signature(0); rand_body(q, 3); put_chunk(32'h49444154, q);     // before IHDR
    put_signature(0); rand_body(q, 12); put_chunk(32'h49484452, q);    // IHDR length
    put_signature(0); put_ihdr(1, 1, 8'd16, 8'd3, 8'd0, 8'd0, 8'd0);   // palette deep
    put_signature(0); put_ihdr(1, 1, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0);
    rand_body(q, 2); put_chunk(32'h74524E53, q);                        // gray tRNS ok
    rand_body(q, 2); put_chunk(32'h74524E53, q);                        // second tRNS
    put_signature(0); put_ihdr(1, 1, 8'd8, 8'd4, 8'd0, 8'd0, 8'd0);
    rand_body(q, 2); put_chunk(32'h74524E53, q);                        // tRNS color type
    put_signature(0); put_ihdr(1, 1, 8'd8, 8'd3, 8'd0, 8'd0, 8'd0);
    put_header_only(32'h504C5445, 32'd771);                             // palette too long
    put_signature(0); put_ihdr(2, 2, 8'd8, 8'd2, 8'd0, 8'd0, 8'd0);
    rand_body(q, 768); put_chunk(32'h504C5445, q);                      // full palette
    put_header_only(32'h74524E53, 32'd257);                             // tRNS too long
    put_signature(0); put_ihdr(1, 1, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0);
    q = {}; put_chunk(32'h49484452, q);                                 // second IHDR
    put_signature(0); put_ihdr(1, 1, 8'd8, 8'd2, 8'd0, 8'd0, 8'd0);
    q = {}; put_chunk(32'h49454E44, q, 1);                              // IEND bad CRC
    put_byte(8'hFF, 1);
    for (int i = 0; i < 7; i++) put_byte(8'h00);

    // Random images, then a backpressure phase where the sink holds off.
    while (bytes_built < 1400) put_image();
    wait (pending_bytes.size() == 0);
    hold_sink = 1;
    put_image(); put_signature(0); put_ihdr(3, 3, 8'd8, 8'd0, 8'd0, 8'd0, 8'd0);
    rand_body(q, 60); put_chunk(32'h49444154, q);
    q = {}; put_chunk(32'h49454E44, q);
    repeat (200) @(posedge clk);
    hold_sink = 0;
    while (bytes_built < 1750) put_image();
    wait (pending_bytes.size() < 150);
    idle_bias = 0;   // no idling for the tail of the run
    wait (pending_bytes.size() == 0);
    wait (expected_results.size() == 0 && !s_tvalid);
    repeat (20) @(posedge clk);

    $display("covered %0d bytes: %0d chunk/error reports, %0d image data bytes",
             items_sent, reports_seen, payloads_seen);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("png_chunk_stream_checker_core test passed");
    else
      $display("png_chunk_stream_checker_core test failed");
    $finish;
  end
endmodule
